[hw/rtl/ic3_pkg.sv]
// Shared types, constants and helpers for the 3x3 image convolution block.
// No dependencies.
`default_nettype none
package ic3_pkg;
	localparam int MAX_WIDTH = 2048;
	localparam int COL_W = 12;
	localparam int ROW_W = 12;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int SUM_W = 29;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOTTOM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED_OUT = 3'd6;

	typedef struct packed {
		logic [7:0] pixel;
		logic frame_start;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] filtered;
		logic row_end;
		logic frame_end;
	} out_word_t;

	// One window ready for the back end.
	typedef struct packed {
		logic [8:0][7:0] pix;
		logic row_end;
		logic frame_end;
	} win_word_t;
endpackage
`default_nettype wire

[hw/rtl/image_convolution_3x3_top.sv]
// Top level of the 3x3 image convolution block: config registers and wiring.
// Depends on ic3_pkg, ic3_front, ic3_queue, ic3_back.
//
//  Port group     Direction  Words
//  in_*           in         one pixel word with frame_start
//  out_*          out        one filtered result with row_end, frame_end
//  cfg_*          in         register write, index 0..6, no read-back
//
// The front end reads the line buffers for a pixel, then writes them back before the next.
// The back end takes one window at a time through 9 MAC taps and 30 divider steps.
// A 4-deep queue lets the front keep taking pixels while the back end works.
// Reset is asynchronous, active low; it clears control state and loads config defaults.
// Either side may stall; no word is lost or repeated.
`default_nettype none
module image_convolution_3x3_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ic3_pkg::in_word_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output ic3_pkg::out_word_t out_data,
	input wire logic cfg_we,
	input wire logic [ic3_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [ic3_pkg::CFG_DATA_W-1:0] cfg_data
);
	logic [11:0] line_width_q;
	logic [12:0] frame_height_q;
	logic [47:0] coeff_top_q, coeff_mid_q, coeff_bottom_q;
	logic [15:0] divisor_q;
	logic unsigned_q;
	logic fw_valid, fw_ready, bw_valid, bw_ready;
	ic3_pkg::win_word_t fw_word, bw_word;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= 12'd640;
			frame_height_q <= 13'd480;
			coeff_top_q <= '0;
			coeff_mid_q <= '0;
			coeff_bottom_q <= '0;
			divisor_q <= 16'd1;
			unsigned_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ic3_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data[11:0];
				ic3_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[12:0];
				ic3_pkg::REG_COEFF_TOP: coeff_top_q <= cfg_data;
				ic3_pkg::REG_COEFF_MID: coeff_mid_q <= cfg_data;
				ic3_pkg::REG_COEFF_BOTTOM: coeff_bottom_q <= cfg_data;
				ic3_pkg::REG_DIVISOR: divisor_q <= cfg_data[15:0];
				ic3_pkg::REG_UNSIGNED_OUT: unsigned_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ic3_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_word(in_data), .line_width(line_width_q), .frame_height(frame_height_q),
		.win_valid(fw_valid), .win_ready(fw_ready), .win_word(fw_word)
	);

	ic3_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(fw_valid), .in_ready(fw_ready),
		.in_word(fw_word), .out_valid(bw_valid), .out_ready(bw_ready), .out_word(bw_word)
	);

	ic3_back u_back (
		.clk(clk), .arst_n(arst_n), .win_valid(bw_valid), .win_ready(bw_ready),
		.win_word(bw_word), .coeff_top(coeff_top_q), .coeff_mid(coeff_mid_q),
		.coeff_bottom(coeff_bottom_q), .divisor(divisor_q),
		.unsigned_output(unsigned_q), .out_valid(out_valid), .out_ready(out_ready),
		.out_word(out_data)
	);
endmodule
`default_nettype wire

[hw/rtl/ic3_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`default_nettype none
module ic3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[hw/rtl/ic3_front.sv]
// Front end: line buffers, window, position counters; emits full windows.
// Depends on ic3_pkg and ic3_ram.
`default_nettype none
module ic3_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ic3_pkg::in_word_t in_word,
	input wire logic [ic3_pkg::COL_W-1:0] line_width,
	input wire logic [12:0] frame_height,
	output logic win_valid,
	input wire logic win_ready,
	output ic3_pkg::win_word_t win_word
);
	typedef enum logic [1:0] {
		ST_READ = 2'b01,
		ST_SHIFT = 2'b10
	} state_t;

	state_t state_q;
	logic [ic3_pkg::COL_W-1:0] col_q;
	logic [ic3_pkg::ROW_W-1:0] row_q;
	logic [7:0] px_q;
	logic [ic3_pkg::COL_W-1:0] col_cur;
	logic [ic3_pkg::ROW_W-1:0] row_cur;
	logic [ic3_pkg::COL_W-1:0] col_hold_q;
	logic [ic3_pkg::ROW_W-1:0] row_hold_q;
	logic [8:0][7:0] win_q;
	logic [7:0] above1, above2;
	logic [ic3_pkg::ADDR_W-1:0] addr;
	logic [12:0] eff_w, eff_h;
	logic shift_en, out_valid_q;
	ic3_pkg::win_word_t out_q;

	// Effective geometry.
	always_comb begin
		if (line_width < 12'd3) begin
			eff_w = 13'd3;
		end else if ({1'b0, line_width} > 13'(ic3_pkg::MAX_WIDTH)) begin
			eff_w = 13'(ic3_pkg::MAX_WIDTH);
		end else begin
			eff_w = {1'b0, line_width};
		end
		if (frame_height < 13'd3) begin
			eff_h = 13'd3;
		end else if (frame_height > 13'd4096) begin
			eff_h = 13'd4096;
		end else begin
			eff_h = frame_height;
		end
	end

	// Accept a pixel in READ when the output register can take a window.
	assign in_ready = (state_q == ST_READ) && (!out_valid_q || win_ready);
	assign col_cur = in_word.frame_start ? '0 : col_q;
	assign row_cur = in_word.frame_start ? '0 : row_q;
	assign addr = col_cur[ic3_pkg::ADDR_W-1:0];
	assign shift_en = (state_q == ST_SHIFT);

	ic3_ram #(.WIDTH(8), .DEPTH(ic3_pkg::MAX_WIDTH)) u_line1 (
		.clk(clk), .we(shift_en), .waddr(col_hold_q[ic3_pkg::ADDR_W-1:0]),
		.wdata(px_q), .re(in_valid && in_ready), .raddr(addr), .rdata(above1)
	);
	ic3_ram #(.WIDTH(8), .DEPTH(ic3_pkg::MAX_WIDTH)) u_line2 (
		.clk(clk), .we(shift_en), .waddr(col_hold_q[ic3_pkg::ADDR_W-1:0]),
		.wdata(above1), .re(in_valid && in_ready), .raddr(addr), .rdata(above2)
	);

	// Sequencer: read line buffers, then shift window and write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READ;
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && win_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_READ: begin
					if (in_valid && in_ready) begin
						px_q <= in_word.pixel;
						col_hold_q <= col_cur;
						row_hold_q <= row_cur;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					win_q <= {px_q, win_q[8], win_q[7], above1, win_q[5], win_q[4],
						above2, win_q[2], win_q[1]};
					out_q.pix <= {px_q, win_q[8], win_q[7], above1, win_q[5], win_q[4],
						above2, win_q[2], win_q[1]};
					out_q.row_end <= ({1'b0, col_hold_q} == eff_w - 13'd1);
					out_q.frame_end <= ({1'b0, col_hold_q} == eff_w - 13'd1) &&
						({1'b0, row_hold_q} == eff_h - 13'd1);
					if (col_hold_q >= 12'd2 && row_hold_q >= 12'd2) begin
						out_valid_q <= 1'b1;
					end
					if ({1'b0, col_hold_q} + 13'd1 >= eff_w) begin
						col_q <= '0;
						if ({1'b0, row_hold_q} + 13'd1 >= eff_h) begin
							row_q <= '0;
						end else begin
							row_q <= row_hold_q + 12'd1;
						end
					end else begin
						col_q <= col_hold_q + 12'd1;
						row_q <= row_hold_q;
					end
					state_q <= ST_READ;
				end
				default: state_q <= ST_READ;
			endcase
		end
	end

	assign win_valid = out_valid_q;
	assign win_word = out_q;

	a_ready_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_READ) else $error("ready outside read");
	a_shift_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_SHIFT) else $error("no shift");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < 13'(ic3_pkg::MAX_WIDTH)) else $error("column overflow");
endmodule
`default_nettype wire

[hw/rtl/ic3_queue.sv]
// Short FIFO between front and back ends.
// Depends on ic3_pkg.
`default_nettype none
module ic3_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ic3_pkg::win_word_t in_word,
	output logic out_valid,
	input wire logic out_ready,
	output ic3_pkg::win_word_t out_word
);
	ic3_pkg::win_word_t slot_q [ic3_pkg::QUEUE_DEPTH];
	logic [ic3_pkg::QUEUE_AW-1:0] wp_q, rp_q;
	logic [ic3_pkg::QUEUE_AW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 3'(ic3_pkg::QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_word = slot_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= in_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(ic3_pkg::QUEUE_DEPTH)) else $error("queue overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[ic3_pkg::QUEUE_AW-1:0] == wp_q - rp_q) else $error("pointer mismatch");
endmodule
`default_nettype wire

[hw/rtl/ic3_back.sv]
// Back end: 3x3 multiply-accumulate, serial signed division and clamping.
// Depends on ic3_pkg.
`default_nettype none
module ic3_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic win_valid,
	output logic win_ready,
	input wire ic3_pkg::win_word_t win_word,
	input wire logic [47:0] coeff_top,
	input wire logic [47:0] coeff_mid,
	input wire logic [47:0] coeff_bottom,
	input wire logic [15:0] divisor,
	input wire logic unsigned_output,
	output logic out_valid,
	input wire logic out_ready,
	output ic3_pkg::out_word_t out_word
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MAC = 4'b0010,
		ST_DIV = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	ic3_pkg::win_word_t w_q;
	logic [3:0] tap_q;
	logic [4:0] bit_q;
	logic signed [ic3_pkg::SUM_W-1:0] acc_q;
	logic [ic3_pkg::SUM_W-1:0] mag_q, quo_q;
	logic [16:0] rem_q;
	logic neg_q, ov_q;
	ic3_pkg::out_word_t res_q;
	logic signed [15:0] coef;
	logic signed [24:0] prod;
	logic [143:0] coeffs;
	logic [15:0] dv;
	logic [16:0] rtrial;
	logic signed [ic3_pkg::SUM_W:0] q_s;
	logic signed [15:0] clamped;

	assign coeffs = {coeff_bottom, coeff_mid, coeff_top};
	assign coef = coeffs[tap_q*16 +: 16];
	assign prod = coef * $signed({1'b0, w_q.pix[tap_q]});
	assign dv = (divisor == '0) ? 16'd1 : divisor;
	assign rtrial = {rem_q[15:0], mag_q[ic3_pkg::SUM_W-1]};
	assign win_ready = state_q == ST_IDLE;
	assign out_valid = ov_q;
	assign out_word = res_q;

	// Clamp the signed quotient.
	always_comb begin
		q_s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		if (unsigned_output) begin
			if (q_s < 0) clamped = 16'sd0;
			else if (q_s > 255) clamped = 16'sd255;
			else clamped = 16'(q_s);
		end else begin
			if (q_s < -32768) clamped = -16'sd32768;
			else if (q_s > 32767) clamped = 16'sd32767;
			else clamped = 16'(q_s);
		end
	end

	// One tap per cycle, a setup step, then one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
			tap_q <= '0;
			bit_q <= '0;
		end else begin
			if (ov_q && out_ready && state_q != ST_DONE) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (win_valid) begin
						w_q <= win_word;
						acc_q <= '0;
						tap_q <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					acc_q <= acc_q + ic3_pkg::SUM_W'(prod);
					if (tap_q == 4'd8) begin
						state_q <= ST_DIV;
					end else begin
						tap_q <= tap_q + 4'd1;
					end
				end
				ST_DIV: begin
					if (bit_q == 5'd0) begin
						neg_q <= acc_q[ic3_pkg::SUM_W-1];
						mag_q <= acc_q[ic3_pkg::SUM_W-1] ? 29'(-acc_q) : acc_q;
						rem_q <= '0;
						quo_q <= '0;
						bit_q <= 5'd1;
					end else begin
						mag_q <= mag_q << 1;
						if (rtrial >= {1'b0, dv}) begin
							rem_q <= rtrial - {1'b0, dv};
							quo_q <= {quo_q[ic3_pkg::SUM_W-2:0], 1'b1};
						end else begin
							rem_q <= rtrial;
							quo_q <= {quo_q[ic3_pkg::SUM_W-2:0], 1'b0};
						end
						if (bit_q == 5'(ic3_pkg::SUM_W)) begin
							bit_q <= '0;
							state_q <= ST_DONE;
						end else begin
							bit_q <= bit_q + 5'd1;
						end
					end
				end
				ST_DONE: begin
					if (!ov_q || out_ready) begin
						res_q.filtered <= clamped;
						res_q.row_end <= w_q.row_end;
						res_q.frame_end <= w_q.frame_end;
						ov_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> tap_q <= 4'd8) else $error("tap overrun");
	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!ov_q || out_ready)) |=> ov_q) else $error("lost result");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		win_ready |-> state_q == ST_IDLE) else $error("ready while busy");
endmodule
`default_nettype wire
